FILE: rtl/core/skec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stereo karaoke effect chain.
// No dependencies; the top level, sequencer and datapath import this package.
package skec_pkg;

    localparam int DEF_SAMPLE_BITS = 24;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;
    localparam int COEF_BITS       = 17;

    localparam logic [CFG_DATA_BITS-1:0] GAIN_ONE  = 16'd16384;
    localparam logic [COEF_BITS-1:0]     GAIN_MAX  = 17'd32768;
    localparam logic [COEF_BITS-1:0]     LEVEL_ONE = 17'd32768;
    localparam logic [CFG_DATA_BITS-1:0] LEVEL_MIN = 16'd33;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CHAIN_ENABLE    = 3'd0,
        CFG_SUPPRESS_ENABLE = 3'd1,
        CFG_MUSIC_GAIN      = 3'd2,
        CFG_VOCAL_GAIN      = 3'd3,
        CFG_ECHO_LEVEL      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_ROUND,
        S_ECHO,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_gain;
        logic round;
        logic echo;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

    // Configuration as seen by the datapath, already decoded.
    typedef struct packed {
        logic                 suppress_on;
        logic                 gain_on;
        logic                 echo_on;
        logic                 clear_store;
        logic [COEF_BITS-1:0] music_gain;
        logic [COEF_BITS-1:0] vocal_gain;
        logic [COEF_BITS-1:0] level;
    } t_dp_cfg;

endpackage

FILE: rtl/core/skec_in_if.sv
`timescale 1ns / 1ps
// Input frame channel: valid/ready handshake with a stereo frame payload.
// Depends on nothing; the sample width is an interface parameter.
interface skec_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last_in;

    modport source (output valid, output left_in, output right_in, output block_last_in,
                    input ready);
    modport sink   (input valid, input left_in, input right_in, input block_last_in,
                    output ready);
endinterface

FILE: rtl/core/skec_out_if.sv
`timescale 1ns / 1ps
// Output frame channel: valid/ready handshake with a processed stereo frame.
// Depends on nothing; the sample width is an interface parameter.
interface skec_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_last_out;

    modport source (output valid, output left_out, output right_out, output block_last_out,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input block_last_out,
                    output ready);
endinterface

FILE: rtl/core/stereo_karaoke_effect_chain_top.sv
`timescale 1ns / 1ps
// Top level of the stereo karaoke effect chain: configuration registers,
// sequencer and datapath. Depends on skec_pkg, skec_in_if, skec_out_if, skec_ctrl, skec_dp.
//
//  Channel   Direction  Handshake         Payload
//  i_frame   in         valid/ready       left_in, right_in, block_last_in
//  o_frame   out        valid/ready       left_out, right_out, block_last_out
//  i_cfg_*   in         write enable      register index and 16-bit data
//
// A frame passes through gain multiply, rounding, echo multiply and mix, one state
// each; only the gain multiply and echo multiply steps have multipliers of their own.
// The result is registered at the end of the mix step. Reset is synchronous and active low.
// The output register holds a finished frame while the next one is processed; only
// the mix step waits when the previous result has not yet been taken.
module stereo_karaoke_effect_chain_top #(
    parameter int SAMPLE_BITS = skec_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    skec_in_if.sink                              i_frame,
    skec_out_if.source                           o_frame,
    input  logic                                 i_cfg_we,
    input  logic [skec_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [skec_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import skec_pkg::*;

    logic                     r_chain_en;
    logic                     r_sup_en;
    logic [CFG_DATA_BITS-1:0] r_music_gain;
    logic [CFG_DATA_BITS-1:0] r_vocal_gain;
    logic [CFG_DATA_BITS-1:0] r_echo_level;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_dp_cfg  dp_cfg;
    logic     clear_store;

    assign clear_store = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_CHAIN_ENABLE) &&
                         !i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_en   <= 1'b0;
            r_sup_en     <= 1'b1;
            r_music_gain <= GAIN_ONE;
            r_vocal_gain <= '0;
            r_echo_level <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHAIN_ENABLE:    r_chain_en   <= i_cfg_data[0];
                CFG_SUPPRESS_ENABLE: r_sup_en     <= i_cfg_data[0];
                CFG_MUSIC_GAIN:      r_music_gain <= i_cfg_data;
                CFG_VOCAL_GAIN:      r_vocal_gain <= i_cfg_data;
                CFG_ECHO_LEVEL:      r_echo_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Gains above GAIN_MAX (twice unity) act as GAIN_MAX; a level above full scale acts as full scale.
    always_comb begin
        dp_cfg.suppress_on = r_chain_en && r_sup_en;
        dp_cfg.gain_on     = r_chain_en && ((r_music_gain != GAIN_ONE) || (r_vocal_gain != '0));
        dp_cfg.echo_on     = r_chain_en && (r_echo_level >= LEVEL_MIN);
        dp_cfg.clear_store = clear_store;
        dp_cfg.music_gain  = ({1'b0, r_music_gain} > GAIN_MAX) ? GAIN_MAX
                                                               : {1'b0, r_music_gain};
        dp_cfg.vocal_gain  = ({1'b0, r_vocal_gain} > GAIN_MAX) ? GAIN_MAX
                                                               : {1'b0, r_vocal_gain};
        dp_cfg.level       = ({1'b0, r_echo_level} > LEVEL_ONE) ? LEVEL_ONE
                                                                : {1'b0, r_echo_level};
    end

    skec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_frame.valid),
        .i_out_ready (o_frame.ready),
        .i_stat      (stat),
        .o_in_ready  (i_frame.ready),
        .o_cmd       (cmd)
    );

    skec_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (dp_cfg),
        .i_left      (i_frame.left_in),
        .i_right     (i_frame.right_in),
        .i_last      (i_frame.block_last_in),
        .i_out_ready (o_frame.ready),
        .o_left      (o_frame.left_out),
        .o_right     (o_frame.right_out),
        .o_last      (o_frame.block_last_out),
        .o_stat      (stat)
    );

    assign o_frame.valid = stat.out_valid;

endmodule

FILE: rtl/core/skec_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the effect chain: steps each frame through gain, round, echo and mix.
// Depends on skec_pkg for the state type and the command and status structs.
module skec_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  skec_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output skec_pkg::t_dp_cmd  o_cmd
);
    import skec_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;
    logic   in_ready;

    assign out_free = !i_stat.out_valid || i_out_ready;
    // A new frame enters from idle, or during the mix step when the result can be stored.
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_GAIN;
            end
            S_GAIN:  n_state = S_ROUND;
            S_ROUND: n_state = S_ECHO;
            S_ECHO:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = i_in_valid ? S_GAIN : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = in_ready;
        o_cmd.load     = in_ready && i_in_valid;
        o_cmd.mul_gain = (r_state == S_GAIN);
        o_cmd.round    = (r_state == S_ROUND);
        o_cmd.echo     = (r_state == S_ECHO);
        o_cmd.finish   = (r_state == S_FIN) && out_free;
    end

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_GAIN)
        else $error("accepted frame did not start the gain step");
    a_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GAIN |=> r_state == S_ROUND ##1 r_state == S_ECHO ##1 r_state == S_FIN)
        else $error("frame steps out of order");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> i_stat.out_valid)
        else $error("finished frame not presented");
    a_hold_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && !out_free |=> r_state == S_FIN && !$past(o_cmd.load))
        else $error("mix step left while the output register was full");
`endif

endmodule

FILE: rtl/core/skec_dp.sv
`timescale 1ns / 1ps
// Datapath of the effect chain: suppression, gain multipliers, echo stores and mix.
// Depends on skec_pkg for the command, status and configuration structs.
module skec_dp #(
    parameter int SAMPLE_BITS = skec_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skec_pkg::t_dp_cmd             i_cmd,
    input  skec_pkg::t_dp_cfg             i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic                          i_last,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right,
    output logic                          o_last,
    output skec_pkg::t_dp_stat            o_stat
);
    import skec_pkg::*;

    localparam int W    = SAMPLE_BITS;
    localparam int XW   = W + 1;        // after suppression
    localparam int PGW  = XW + 18;      // gain product
    localparam int DW   = W + 2;        // after gain, also the echo store width
    localparam int PEW  = DW + 18;      // echo products and their sum
    localparam int SW   = W + 5;        // input of the output saturation
    localparam int NSW  = DW + 1;       // new store value before saturation

    localparam logic signed [SW-1:0]  OUT_MAX = {6'b000000, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0]  OUT_MIN = {6'b111111, {(W-1){1'b0}}};
    localparam logic signed [NSW-1:0] ST_MAX  = {2'b00, {(DW-1){1'b1}}};
    localparam logic signed [NSW-1:0] ST_MIN  = {2'b11, {(DW-1){1'b0}}};
    localparam logic signed [PGW-1:0] G_HALF  = PGW'(8192);
    localparam logic signed [PEW-1:0] E_HALF  = PEW'(16384);

    function automatic logic signed [W-1:0] sat_out(input logic signed [SW-1:0] v);
        if (v > OUT_MAX) return OUT_MAX[W-1:0];
        if (v < OUT_MIN) return OUT_MIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_store(input logic signed [NSW-1:0] v);
        if (v > ST_MAX) return ST_MAX[DW-1:0];
        if (v < ST_MIN) return ST_MIN[DW-1:0];
        return v[DW-1:0];
    endfunction

    logic signed [XW-1:0]  r_x_l, r_x_r;
    logic                  r_last;
    logic signed [PGW-1:0] r_pg_l, r_pg_r;
    logic signed [DW-1:0]  r_dry_l, r_dry_r;
    logic signed [PEW-1:0] r_pa_l, r_pb_l, r_pa_r, r_pb_r;
    logic signed [DW-1:0]  r_store_l, r_store_r;
    logic signed [W-1:0]   r_out_l, r_out_r;
    logic                  r_out_last;
    logic                  r_out_valid;

    logic signed [XW-1:0]  side;
    logic signed [17:0]    gm_s, gv_s, wet_s, dryw_s;
    logic signed [PGW-1:0] rnd_l, rnd_r;
    logic signed [PEW-1:0] mix_l, mix_r;
    logic signed [NSW-1:0] ns_l, ns_r;
    logic signed [SW-1:0]  pre_l, pre_r;

    assign side   = XW'(i_left) - XW'(i_right);
    assign gm_s   = {1'b0, i_cfg.music_gain};
    assign gv_s   = {1'b0, i_cfg.vocal_gain};
    assign wet_s  = {1'b0, i_cfg.level};
    assign dryw_s = {1'b0, LEVEL_ONE - i_cfg.level};
    assign rnd_l  = r_pg_l + G_HALF;
    assign rnd_r  = r_pg_r + G_HALF;
    assign mix_l  = r_pa_l + r_pb_l + E_HALF;
    assign mix_r  = r_pa_r + r_pb_r + E_HALF;
    // Half of the old store, rounded toward minus infinity, plus the dry sample.
    assign ns_l   = NSW'(r_dry_l) + NSW'(r_store_l >>> 1);
    assign ns_r   = NSW'(r_dry_r) + NSW'(r_store_r >>> 1);
    assign pre_l  = i_cfg.echo_on ? SW'(mix_l[PEW-1:15]) : SW'(r_dry_l);
    assign pre_r  = i_cfg.echo_on ? SW'(mix_r[PEW-1:15]) : SW'(r_dry_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_l  <= i_cfg.suppress_on ? side : XW'(i_left);
            r_x_r  <= i_cfg.suppress_on ? -side : XW'(i_right);
            r_last <= i_last;
        end
        if (i_cmd.mul_gain) begin
            r_pg_l <= PGW'(r_x_l) * PGW'(gm_s);
            r_pg_r <= PGW'(r_x_r) * PGW'(gv_s);
        end
        if (i_cmd.round) begin
            r_dry_l <= i_cfg.gain_on ? rnd_l[DW+13:14] : DW'(r_x_l);
            r_dry_r <= i_cfg.gain_on ? rnd_r[DW+13:14] : DW'(r_x_r);
        end
        if (i_cmd.echo) begin
            r_pa_l <= PEW'(r_dry_l) * PEW'(dryw_s);
            r_pb_l <= PEW'(r_store_l) * PEW'(wet_s);
            r_pa_r <= PEW'(r_dry_r) * PEW'(dryw_s);
            r_pb_r <= PEW'(r_store_r) * PEW'(wet_s);
        end
        if (i_cmd.finish) begin
            r_out_l    <= sat_out(pre_l);
            r_out_r    <= sat_out(pre_r);
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_l   <= '0;
            r_store_r   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.clear_store) begin
                r_store_l <= '0;
                r_store_r <= '0;
            end else if (i_cmd.echo && i_cfg.echo_on) begin
                r_store_l <= sat_store(ns_l);
                r_store_r <= sat_store(ns_r);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_left           = r_out_l;
    assign o_right          = r_out_r;
    assign o_last           = r_out_last;
    assign o_stat.out_valid = r_out_valid;

endmodule
